>>> rtl/sqhm_pkg.sv
// Shared types and constants for the sample qualify hysteresis monitor.
`default_nettype none

package sqhm_pkg;

	// Field widths
	localparam int CHANNEL_W   = 5;
	localparam int VALUE_W     = 8;
	localparam int DEVIATION_W = 16;
	localparam int EVENT_W     = 3;
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 8;

	// Channels below this count are served; others answer zero
	localparam int CHANNEL_COUNT = 32;

	// Monitored channels
	localparam logic [CHANNEL_W-1:0] CH_BATTERY = 5'd7;
	localparam logic [CHANNEL_W-1:0] CH_PA_TEMP = 5'd23;

	// Deviation limit, 2.0 in unsigned 8.8
	localparam logic [DEVIATION_W-1:0] STEADY_LIMIT = 16'd512;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_VBAT_LOW  = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_VBAT_HIGH = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PA_LOW    = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_PA_HIGH   = 4'd3;

	// Event codes
	typedef enum logic [EVENT_W-1:0] {
		EV_NONE     = 3'd0,
		EV_BAT_LOW  = 3'd1,
		EV_BAT_HIGH = 3'd2,
		EV_PA_COOL  = 3'd3,
		EV_PA_HOT   = 3'd4
	} event_code_t;

endpackage

`default_nettype wire

>>> rtl/sqhm_channels.sv
// Handshake channels for samples, results and register writes.
`default_nettype none

interface sqhm_sample_if import sqhm_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [CHANNEL_W-1:0]   channel;
	logic [VALUE_W-1:0]     sample_value;
	logic [DEVIATION_W-1:0] sample_deviation;

	modport source (output valid, channel, sample_value, sample_deviation, input ready);
	modport sink (input valid, channel, sample_value, sample_deviation, output ready);
endinterface

interface sqhm_result_if import sqhm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] qualified_value;
	logic [EVENT_W-1:0] event_code;

	modport source (output valid, qualified_value, event_code, input ready);
	modport sink (input valid, qualified_value, event_code, output ready);
endinterface

interface sqhm_cfg_if import sqhm_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/sample_qualify_hysteresis_monitor.sv
// Top level: sample qualifier with battery and PA temperature hysteresis monitors.
`default_nettype none

// Takes ADC sample items and returns exactly one result item for each, through
// the input and result registers. A sample whose deviation exceeds 2.0 (or
// whose channel is not below CHANNEL_COUNT) returns zero and no event. Steady
// samples on channel 7 (battery) and 23 (PA temperature) are compared exactly,
// in hundredths, against thresholds set by four signed 8-bit step registers,
// and an event is returned when the channel's two-level mode flips. Throughput
// is one item per cycle unless the result side stalls: the input register feeds
// one evaluate stage whose single-bit mode update closes as the item leaves it,
// and the result register lets a new item enter while a result waits. Register
// writes are taken at any time and should land only while the block is idle.
module sample_qualify_hysteresis_monitor
	import sqhm_pkg::*;
(
	input  wire          clk,
	input  wire          arst_n,
	sqhm_cfg_if.sink     cfg,
	sqhm_sample_if.sink  sample,
	sqhm_result_if.source result
);

	// Threshold step registers
	logic signed [CFG_DATA_W-1:0] vbat_low_q;
	logic signed [CFG_DATA_W-1:0] vbat_high_q;
	logic signed [CFG_DATA_W-1:0] pa_low_q;
	logic signed [CFG_DATA_W-1:0] pa_high_q;

	// Mode state
	logic bat_mode_q;
	logic pa_mode_q;

	// Input stage
	logic                   valid_s1;
	logic [CHANNEL_W-1:0]   channel_s1;
	logic [VALUE_W-1:0]     value_s1;
	logic [DEVIATION_W-1:0] deviation_s1;

	// Result stage
	logic               out_valid_q;
	logic [VALUE_W-1:0] out_value_q;
	event_code_t        out_event_q;

	// Evaluate stage outputs
	logic               advance_s1;
	logic               channel_ok;
	logic               steady;
	logic [19:0]        bat_mag;
	logic signed [22:0] bat_level;
	logic signed [22:0] bat_lo;
	logic signed [22:0] bat_hi;
	logic [15:0]        pa_mag;
	logic signed [17:0] pa_level;
	logic signed [17:0] pa_lo;
	logic signed [17:0] pa_hi;
	logic [VALUE_W-1:0] qual_value;
	event_code_t        event_nx;
	logic               bat_mode_nx;
	logic               pa_mode_nx;

	// Register writes are always taken
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vbat_low_q  <= '0;
			vbat_high_q <= '0;
			pa_low_q    <= '0;
			pa_high_q   <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_VBAT_LOW:  vbat_low_q  <= cfg.data;
				REG_VBAT_HIGH: vbat_high_q <= cfg.data;
				REG_PA_LOW:    pa_low_q    <= cfg.data;
				REG_PA_HIGH:   pa_high_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	// Advance the evaluate stage when the result register is free or drains
	assign advance_s1   = valid_s1 && (!out_valid_q || result.ready);
	assign sample.ready = !valid_s1 || advance_s1;

	// Capture an item into the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			channel_s1   <= sample.channel;
			value_s1     <= sample.sample_value;
			deviation_s1 <= sample.sample_deviation;
		end
	end

	// Qualify the sample
	assign channel_ok = {2'b00, channel_s1} < 7'(CHANNEL_COUNT);
	assign steady     = deviation_s1 <= STEADY_LIMIT;

	// Battery level and thresholds in hundredths of mV
	assign bat_mag   = 20'(value_s1) * 20'd3524;
	assign bat_level = signed'({3'b000, bat_mag});
	assign bat_lo    = 23'sd530000 + 23'(vbat_low_q) * 23'sd10000;
	assign bat_hi    = 23'sd630000 + 23'(vbat_high_q) * 23'sd10000;

	// PA temperature and thresholds in hundredths of a degree
	assign pa_mag   = 16'(value_s1) * 16'd160;
	assign pa_level = signed'({2'b00, pa_mag}) - 18'sd27315;
	assign pa_lo    = 18'sd6000 + 18'(pa_low_q) * 18'sd200;
	assign pa_hi    = 18'sd7300 + 18'(pa_high_q) * 18'sd200;

	// Apply hysteresis to the addressed monitor; hold the mode inside the band
	always_comb begin
		qual_value  = '0;
		event_nx    = EV_NONE;
		bat_mode_nx = bat_mode_q;
		pa_mode_nx  = pa_mode_q;
		if (channel_ok && steady) begin
			qual_value = value_s1;
			if (channel_s1 == CH_BATTERY) begin
				if (bat_level > bat_hi) begin
					if (!bat_mode_q) begin
						bat_mode_nx = 1'b1;
						event_nx    = EV_BAT_HIGH;
					end
				end else if (bat_level <= bat_lo) begin
					if (bat_mode_q) begin
						bat_mode_nx = 1'b0;
						event_nx    = EV_BAT_LOW;
					end
				end
			end else if (channel_s1 == CH_PA_TEMP) begin
				if (pa_level > pa_hi) begin
					if (!pa_mode_q) begin
						pa_mode_nx = 1'b1;
						event_nx   = EV_PA_HOT;
					end
				end else if (pa_level <= pa_lo) begin
					if (pa_mode_q) begin
						pa_mode_nx = 1'b0;
						event_nx   = EV_PA_COOL;
					end
				end
			end
		end
	end

	// Commit mode changes as the item leaves the evaluate stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bat_mode_q <= 1'b1;
			pa_mode_q  <= 1'b0;
		end else if (advance_s1) begin
			bat_mode_q <= bat_mode_nx;
			pa_mode_q  <= pa_mode_nx;
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			out_value_q <= qual_value;
			out_event_q <= event_nx;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.qualified_value = out_value_q;
	assign result.event_code      = out_event_q;

`ifndef SYNTHESIS
	// Input stalls only while a full pipe waits on the result side
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!sample.ready |-> (valid_s1 && out_valid_q && !result.ready))
		else $error("input stalled without a blocked result");

	// Battery mode changes only with a battery event
	a_bat_flip: assert property (@(posedge clk) disable iff (!arst_n)
		(bat_mode_q != $past(bat_mode_q)) |->
		$past(advance_s1 && (event_nx == EV_BAT_LOW || event_nx == EV_BAT_HIGH)))
		else $error("battery mode changed without an event");

	// PA mode changes only with a PA event
	a_pa_flip: assert property (@(posedge clk) disable iff (!arst_n)
		(pa_mode_q != $past(pa_mode_q)) |->
		$past(advance_s1 && (event_nx == EV_PA_COOL || event_nx == EV_PA_HOT)))
		else $error("PA mode changed without an event");

	// A battery high event leaves the battery monitor in high mode
	a_high_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(advance_s1 && event_nx == EV_BAT_HIGH) |=> bat_mode_q)
		else $error("battery high event without high mode");
`endif

endmodule

`default_nettype wire

>>> tb/sample_qualify_hysteresis_monitor_test.sv
// Testbench: sample qualifier and hysteresis monitors against a scoreboard predictor.
`timescale 1ns / 100ps

module sample_qualify_hysteresis_monitor_test
	import sqhm_pkg::*;
();

	// Register indexes past the last register; writes there must be dropped
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LO = 4'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_HI = 4'd15;

	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 172;

	typedef struct {
		logic [VALUE_W-1:0] qualified_value;
		event_code_t        event_code;
	} qualified_result_t;

	// Predicts one result item per sample and checks results in order
	class sample_qualifier_model;
		logic signed [CFG_DATA_W-1:0] bat_lo_step;
		logic signed [CFG_DATA_W-1:0] bat_hi_step;
		logic signed [CFG_DATA_W-1:0] pa_lo_step;
		logic signed [CFG_DATA_W-1:0] pa_hi_step;
		bit                           bat_mode_up;
		bit                           pa_mode_up;
		qualified_result_t            expected_results[$];
		int                           mismatches;

		function new();
			bat_lo_step = '0;
			bat_hi_step = '0;
			pa_lo_step  = '0;
			pa_hi_step  = '0;
			bat_mode_up = 1'b1;
			pa_mode_up  = 1'b0;
			mismatches  = 0;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
			case (index)
				REG_VBAT_LOW:  bat_lo_step = data;
				REG_VBAT_HIGH: bat_hi_step = data;
				REG_PA_LOW:    pa_lo_step  = data;
				REG_PA_HIGH:   pa_hi_step  = data;
				default: ;
			endcase
		endfunction

		// Flip the mode up above hi, down at or below lo; report the flip
		function event_code_t track_mode(inout bit mode_up, input int level, input int lo,
				input int hi, input event_code_t ev_down, input event_code_t ev_up);
			event_code_t ev;
			ev = EV_NONE;
			if (level > hi) begin
				if (!mode_up) begin
					mode_up = 1'b1;
					ev = ev_up;
				end
			end else if (level <= lo) begin
				if (mode_up) begin
					mode_up = 1'b0;
					ev = ev_down;
				end
			end
			return ev;
		endfunction

		function void note_sample(logic [CHANNEL_W-1:0] ch, logic [VALUE_W-1:0] v,
				logic [DEVIATION_W-1:0] dev);
			qualified_result_t r;
			int level;
			r.qualified_value = '0;
			r.event_code      = EV_NONE;
			if (int'(ch) < CHANNEL_COUNT && dev <= STEADY_LIMIT) begin
				r.qualified_value = v;
				// Levels and thresholds in hundredths of mV / degree C
				if (ch == CH_BATTERY) begin
					level = 3524 * int'(v);
					r.event_code = track_mode(bat_mode_up, level,
						100 * (5300 + 100 * int'(bat_lo_step)),
						100 * (6300 + 100 * int'(bat_hi_step)),
						EV_BAT_LOW, EV_BAT_HIGH);
				end else if (ch == CH_PA_TEMP) begin
					level = 160 * int'(v) - 27315;
					r.event_code = track_mode(pa_mode_up, level,
						100 * (60 + 2 * int'(pa_lo_step)),
						100 * (73 + 2 * int'(pa_hi_step)),
						EV_PA_COOL, EV_PA_HOT);
				end
			end
			expected_results.push_back(r);
		endfunction

		function void check_result(logic [VALUE_W-1:0] value, logic [EVENT_W-1:0] code);
			qualified_result_t exp_r;
			if (expected_results.size() == 0) begin
				$error("result with no sample waiting: qualified_value %0d event_code %0d",
					value, code);
				mismatches++;
				return;
			end
			exp_r = expected_results.pop_front();
			if (value !== exp_r.qualified_value) begin
				$error("qualified_value mismatch: expected %0d, actual %0d",
					exp_r.qualified_value, value);
				mismatches++;
			end
			if (code !== exp_r.event_code) begin
				$error("event_code mismatch: expected %0d, actual %0d",
					exp_r.event_code, code);
				mismatches++;
			end
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   sender_idle_pct;
	int   receiver_stall_pct;

	sample_qualifier_model board;

	sqhm_cfg_if    cfg_ch ();
	sqhm_sample_if sample_ch ();
	sqhm_result_if result_ch ();

	sample_qualify_hysteresis_monitor DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.sample (sample_ch),
		.result (result_ch)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Hard stop in case a handshake never completes
	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	// Drive result ready, stalling at the current rate
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			result_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	// Check every accepted result item
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			board.check_result(result_ch.qualified_value, result_ch.event_code);
	end

	// Offer one sample item, with an optional idle gap first; hold until accepted
	task automatic send_sample(logic [CHANNEL_W-1:0] ch, logic [VALUE_W-1:0] v,
			logic [DEVIATION_W-1:0] dev);
		@(negedge clk);
		if ($urandom_range(99) < sender_idle_pct) begin
			sample_ch.valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		sample_ch.valid            <= 1'b1;
		sample_ch.channel          <= ch;
		sample_ch.sample_value     <= v;
		sample_ch.sample_deviation <= dev;
		do @(posedge clk); while (!sample_ch.ready);
		board.note_sample(ch, v, dev);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		board.write_reg(index, data);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Drop sample valid and hold until every result is back
	task automatic drain();
		@(negedge clk);
		sample_ch.valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
	endtask

	task automatic set_thresholds(logic [CFG_DATA_W-1:0] bat_lo, logic [CFG_DATA_W-1:0] bat_hi,
			logic [CFG_DATA_W-1:0] pa_lo, logic [CFG_DATA_W-1:0] pa_hi);
		write_reg(REG_VBAT_LOW, bat_lo);
		write_reg(REG_VBAT_HIGH, bat_hi);
		write_reg(REG_PA_LOW, pa_lo);
		write_reg(REG_PA_HIGH, pa_hi);
	endtask

	initial begin
		logic [CHANNEL_W-1:0]   ch;
		logic [VALUE_W-1:0]     v;
		logic [DEVIATION_W-1:0] dev;
		logic [CFG_DATA_W-1:0]  steps [4];
		int                     roll;

		board = new();
		sender_idle_pct            = 0;
		receiver_stall_pct         = 0;
		arst_n                     = 1'b0;
		sample_ch.valid            = 1'b0;
		sample_ch.channel          = '0;
		sample_ch.sample_value     = '0;
		sample_ch.sample_deviation = '0;
		cfg_ch.valid               = 1'b0;
		cfg_ch.index               = '0;
		cfg_ch.data                = '0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed items at reset thresholds: battery flips at 150/179, PA at 208/217
		send_sample(CH_BATTERY, 8'd255, 16'd0);
		send_sample(CH_BATTERY, 8'd151, STEADY_LIMIT);
		send_sample(CH_BATTERY, 8'd150, STEADY_LIMIT);
		send_sample(CH_BATTERY, 8'd178, 16'd0);
		send_sample(CH_BATTERY, 8'd179, 16'd0);
		send_sample(CH_BATTERY, 8'd0, STEADY_LIMIT + 16'd1);
		send_sample(CH_BATTERY, 8'd0, 16'd0);
		send_sample(CH_PA_TEMP, 8'd0, 16'd0);
		send_sample(CH_PA_TEMP, 8'd216, 16'd0);
		send_sample(CH_PA_TEMP, 8'd217, 16'd0);
		send_sample(CH_PA_TEMP, 8'd255, 16'd0);
		send_sample(CH_PA_TEMP, 8'd209, STEADY_LIMIT);
		send_sample(CH_PA_TEMP, 8'd208, STEADY_LIMIT);
		send_sample(CH_PA_TEMP, 8'd255, 16'hFFFF);
		send_sample(CH_BATTERY, 8'd255, 16'hFFFF);
		send_sample(5'd0, 8'd255, 16'd0);
		send_sample(5'd31, 8'd170, STEADY_LIMIT);
		send_sample(5'd31, 8'd85, STEADY_LIMIT + 16'd1);
		send_sample(5'd8, 8'd0, 16'd0);
		send_sample(5'd22, 8'd255, 16'hFFFF);

		// Random phases, each with new thresholds and one of four idling patterns
		for (int p = 0; p < PHASES; p++) begin
			drain();
			case (p)
				0: set_thresholds(8'h80, 8'h80, 8'h80, 8'h80);
				1: set_thresholds(8'h7F, 8'h7F, 8'h7F, 8'h7F);
				2: set_thresholds(8'h7F, 8'h80, 8'h7F, 8'h80);
				3: set_thresholds(8'h00, 8'h00, 8'h00, 8'h00);
				default: begin
					foreach (steps[i])
						steps[i] = 8'($urandom_range(40)) - 8'd20;
					set_thresholds(steps[0], steps[1], steps[2], steps[3]);
				end
			endcase
			if (p == 0) begin
				write_reg(REG_UNUSED_LO, 8'($urandom));
				write_reg(REG_UNUSED_HI, 8'($urandom));
			end

			case (p % 4)
				0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
				1: begin sender_idle_pct = 82; receiver_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  receiver_stall_pct = 82; end
				default: begin sender_idle_pct = 11; receiver_stall_pct = 11; end
			endcase

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// Mostly monitored channels, so the modes keep flipping
				roll = $urandom_range(99);
				if (roll < 38)
					ch = CH_BATTERY;
				else if (roll < 76)
					ch = CH_PA_TEMP;
				else
					ch = 5'($urandom_range(31));

				if ($urandom_range(9) == 0)
					v = $urandom_range(1) ? 8'hFF : 8'h00;
				else
					v = 8'($urandom_range(255));

				// Mostly steady, some right at the limit, the rest anywhere
				roll = $urandom_range(99);
				if (roll < 70)
					dev = 16'($urandom_range(int'(STEADY_LIMIT)));
				else if (roll < 80)
					dev = STEADY_LIMIT - 16'd1 + 16'($urandom_range(2));
				else
					dev = 16'($urandom_range(16'hFFFF));

				send_sample(ch, v, dev);
			end
		end

		// Let the last results out before the verdict
		drain();
		repeat (8) @(posedge clk);
		if (board.mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> sample_qualify_hysteresis_monitor.f
rtl/sqhm_pkg.sv
rtl/sqhm_channels.sv
rtl/sample_qualify_hysteresis_monitor.sv
tb/sample_qualify_hysteresis_monitor_test.sv
